// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL; they expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DPT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define DPT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/dpt_pkg.sv =====
// Types and constants of the discovered peer table.
package dpt_pkg;

    localparam int ADDR_W   = 32;
    localparam int PORT_W   = 16;
    localparam int SEQ_W    = 30;
    localparam int TIME_W   = 32;
    localparam int APPID_W  = 32;
    localparam int RSLOT_W  = 4;
    localparam int AGED_W   = 5;
    localparam int ACT_W    = 3;
    localparam int REQ_W    = 2;
    localparam int PDATA_W  = 32;
    localparam int PADDR_W  = 4;

    // request types
    localparam logic [REQ_W-1:0] REQ_ANNOUNCE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SWEEP    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_READ     = 2'd2;

    // packet kinds
    localparam logic KIND_PRESENT = 1'b0;
    localparam logic KIND_LEAVE   = 1'b1;

    // result actions
    localparam logic [ACT_W-1:0] ACT_IGNORED       = 3'd0;
    localparam logic [ACT_W-1:0] ACT_INSERTED      = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REFRESHED     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_REFRESHED_NEW = 3'd3;
    localparam logic [ACT_W-1:0] ACT_REMOVED       = 3'd4;
    localparam logic [ACT_W-1:0] ACT_DROPPED       = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SWEPT         = 3'd6;
    localparam logic [ACT_W-1:0] ACT_READ          = 3'd7;

    // register indexes (byte address / 4)
    localparam logic [1:0] CFG_APP_ID     = 2'd0;
    localparam logic [1:0] CFG_MATCH_MODE = 2'd1;
    localparam logic [1:0] CFG_TTL        = 2'd2;

    localparam logic [TIME_W-1:0] TTL_RESET = 32'd5000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_WALK,
        ST_APPLY,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        OP_MATCH,
        OP_AGED,
        OP_NEWER
    } alu_op_t;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [ADDR_W-1:0]  src_address;
        logic [PORT_W-1:0]  src_port;
        logic               header_valid;
        logic [APPID_W-1:0] packet_app_id;
        logic               packet_kind;
        logic [SEQ_W-1:0]   packet_seq;
        logic               seq_restarted;
        logic [TIME_W-1:0]  now_ms;
        logic [RSLOT_W-1:0] read_slot;
    } in_item_t;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [RSLOT_W-1:0] slot;
        logic [AGED_W-1:0]  aged_count;
        logic               entry_valid;
        logic [ADDR_W-1:0]  entry_address;
        logic [PORT_W-1:0]  entry_port;
        logic [SEQ_W-1:0]   entry_seq;
        logic [TIME_W-1:0]  entry_last_seen;
    } out_item_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [PORT_W-1:0] port;
        logic [SEQ_W-1:0]  seq;
        logic [TIME_W-1:0] last_seen;
    } peer_t;

    typedef struct packed {
        logic set_used;
        logic clr_used;
        logic wr_ident;
        logic wr_seq;
        logic wr_time;
    } store_wr_t;

    typedef struct packed {
        logic [APPID_W-1:0] app_id;
        logic               match_mode;
        logic [TIME_W-1:0]  time_to_live_ms;
    } cfg_t;

endpackage

// ===== hw/rtl/dpt_ifs.sv =====
// Valid/ready channel interfaces for request and result words.
interface dpt_in_if;
    logic               valid;
    logic               ready;
    dpt_pkg::in_item_t  item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface dpt_out_if;
    logic               valid;
    logic               ready;
    dpt_pkg::out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ===== hw/rtl/dpt_store.sv =====
// Peer storage: slot-used flags in flops, peer fields in a registered-read memory.
module dpt_store #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rd_en,
    input  logic [$clog2(TABLE_SLOTS)-1:0] rd_addr,
    output dpt_pkg::peer_t                 rd_peer,
    output logic                           rd_used,
    input  dpt_pkg::store_wr_t             wr,
    input  logic [$clog2(TABLE_SLOTS)-1:0] wr_addr,
    input  dpt_pkg::peer_t                 wr_peer
);
    localparam int IDENT_W = dpt_pkg::ADDR_W + dpt_pkg::PORT_W;

    logic [IDENT_W-1:0]         ident_mem [TABLE_SLOTS];
    logic [dpt_pkg::SEQ_W-1:0]  seq_mem   [TABLE_SLOTS];
    logic [dpt_pkg::TIME_W-1:0] time_mem  [TABLE_SLOTS];

    logic [TABLE_SLOTS-1:0]     used_reg;
    logic [TABLE_SLOTS-1:0]     used_next;
    logic                       rd_used_reg;
    logic [IDENT_W-1:0]         rd_ident_reg;
    logic [dpt_pkg::SEQ_W-1:0]  rd_seq_reg;
    logic [dpt_pkg::TIME_W-1:0] rd_time_reg;

    always_comb
    begin
        used_next = used_reg;
        if (wr.set_used)
        begin
            used_next[wr_addr] = 1'b1;
        end
        if (wr.clr_used)
        begin
            used_next[wr_addr] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            rd_used_reg <= 1'b0;
        end
        else
        begin
            used_reg <= used_next;
            if (rd_en)
            begin
                rd_used_reg <= used_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.wr_ident)
        begin
            ident_mem[wr_addr] <= {wr_peer.address, wr_peer.port};
        end
        if (wr.wr_seq)
        begin
            seq_mem[wr_addr] <= wr_peer.seq;
        end
        if (wr.wr_time)
        begin
            time_mem[wr_addr] <= wr_peer.last_seen;
        end
        if (rd_en)
        begin
            rd_ident_reg <= ident_mem[rd_addr];
            rd_seq_reg   <= seq_mem[rd_addr];
            rd_time_reg  <= time_mem[rd_addr];
        end
    end

    assign rd_used = rd_used_reg;
    assign rd_peer = {rd_ident_reg, rd_seq_reg, rd_time_reg};

endmodule

// ===== hw/rtl/dpt_alu.sv =====
// Shared compare unit: peer match, idle test and index-newer test.
module dpt_alu (
    input  dpt_pkg::alu_op_t            op,
    input  dpt_pkg::peer_t              ent,
    input  logic                        match_mode,
    input  logic [dpt_pkg::TIME_W-1:0]  time_to_live_ms,
    input  logic [dpt_pkg::ADDR_W-1:0]  src_address,
    input  logic [dpt_pkg::PORT_W-1:0]  src_port,
    input  logic [dpt_pkg::SEQ_W-1:0]   packet_seq,
    input  logic                        seq_restarted,
    input  logic [dpt_pkg::TIME_W-1:0]  now_ms,
    output logic                        hit
);
    logic [dpt_pkg::TIME_W-1:0] idle_ms;

    // wrapping elapsed time
    assign idle_ms = now_ms - ent.last_seen;

    always_comb
    begin
        case (op)
            dpt_pkg::OP_MATCH:
                hit = (ent.address == src_address) &&
                      (!match_mode || (ent.port == src_port));
            dpt_pkg::OP_AGED:
                hit = idle_ms > time_to_live_ms;
            dpt_pkg::OP_NEWER:
                hit = seq_restarted || (ent.seq < packet_seq);
            default:
                hit = 1'b0;
        endcase
    end

endmodule

// ===== hw/rtl/dpt_ctrl.sv =====
// Sequencer: walks the table one slot a cycle, applies the update, holds the result.
module dpt_ctrl #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    dpt_in_if.sink                          in_ch,
    dpt_out_if.source                       out_ch,
    input  logic [dpt_pkg::APPID_W-1:0]     app_id,
    output logic                            rd_en,
    output logic [$clog2(TABLE_SLOTS)-1:0]  rd_addr,
    input  dpt_pkg::peer_t                  rd_peer,
    input  logic                            rd_used,
    output dpt_pkg::store_wr_t              wr,
    output logic [$clog2(TABLE_SLOTS)-1:0]  wr_addr,
    output dpt_pkg::peer_t                  wr_peer,
    output dpt_pkg::alu_op_t                alu_op,
    output dpt_pkg::peer_t                  alu_ent,
    input  logic                            alu_hit,
    output dpt_pkg::in_item_t               req
);
    localparam int SLOT_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
    localparam int RS_W   = dpt_pkg::RSLOT_W;
    localparam int AG_W   = dpt_pkg::AGED_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

    dpt_pkg::state_t    state_reg, state_next;
    dpt_pkg::in_item_t  req_reg, req_next;
    logic [SLOT_W-1:0]  eidx_reg, eidx_next;
    logic               found_reg, found_next;
    logic [SLOT_W-1:0]  hit_reg, hit_next;
    logic [dpt_pkg::SEQ_W-1:0] hit_seq_reg, hit_seq_next;
    logic               free_vld_reg, free_vld_next;
    logic [SLOT_W-1:0]  free_reg, free_next;
    logic [CNT_W-1:0]   aged_reg, aged_next;
    dpt_pkg::out_item_t res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    dpt_pkg::out_item_t out_item_reg, out_item_next;

    logic                   accept;
    logic                   hdr_ok;
    logic                   is_sweep;
    logic                   read_in_range;
    logic                   out_load;
    logic [SLOT_W+RS_W-1:0] in_rslot_wide;
    logic [SLOT_W+RS_W-1:0] req_rslot_wide;
    logic [SLOT_W+RS_W-1:0] hit_wide;
    logic [SLOT_W+RS_W-1:0] free_wide;
    logic [CNT_W+AG_W-1:0]  aged_wide;

    assign accept   = in_ch.valid && (state_reg == dpt_pkg::ST_IDLE);
    assign hdr_ok   = in_ch.item.header_valid &&
                      (in_ch.item.packet_app_id == app_id);
    assign is_sweep = (req_reg.req_type == dpt_pkg::REQ_SWEEP);
    assign out_load = (state_reg == dpt_pkg::ST_DONE) &&
                      (!out_valid_reg || out_ch.ready);

    assign in_rslot_wide  = {SLOT_W'(0), in_ch.item.read_slot};
    assign req_rslot_wide = {SLOT_W'(0), req_reg.read_slot};
    assign hit_wide       = {RS_W'(0), hit_reg};
    assign free_wide      = {RS_W'(0), free_reg};
    assign aged_wide      = {AG_W'(0), aged_reg};
    assign read_in_range  = req_rslot_wide < (SLOT_W + RS_W)'(TABLE_SLOTS);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dpt_pkg::ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    case (in_ch.item.req_type)
                        dpt_pkg::REQ_ANNOUNCE:
                            state_next = hdr_ok ? dpt_pkg::ST_WALK : dpt_pkg::ST_DONE;
                        dpt_pkg::REQ_SWEEP:
                            state_next = dpt_pkg::ST_WALK;
                        dpt_pkg::REQ_READ:
                            state_next = dpt_pkg::ST_READ;
                        default:
                            state_next = dpt_pkg::ST_DONE;
                    endcase
                end
            end
            dpt_pkg::ST_READ:
                state_next = dpt_pkg::ST_DONE;
            dpt_pkg::ST_WALK:
            begin
                if (eidx_reg == LAST_SLOT)
                begin
                    state_next = dpt_pkg::ST_APPLY;
                end
            end
            dpt_pkg::ST_APPLY:
                state_next = dpt_pkg::ST_DONE;
            dpt_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = dpt_pkg::ST_IDLE;
                end
            end
            default:
                state_next = dpt_pkg::ST_IDLE;
        endcase
    end

    // outputs toward the store and the compare unit
    always_comb
    begin
        in_ch.ready = (state_reg == dpt_pkg::ST_IDLE);
        rd_en       = 1'b0;
        rd_addr     = eidx_reg + SLOT_W'(1);
        wr          = '0;
        wr_addr     = eidx_reg;
        wr_peer     = {req_reg.src_address, req_reg.src_port,
                       req_reg.packet_seq, req_reg.now_ms};
        alu_op      = dpt_pkg::OP_MATCH;
        alu_ent     = rd_peer;
        case (state_reg)
            dpt_pkg::ST_IDLE:
            begin
                // slot 0 (or the read slot) is fetched on the accept edge
                rd_en   = in_ch.valid;
                rd_addr = (in_ch.item.req_type == dpt_pkg::REQ_READ) ?
                          in_rslot_wide[SLOT_W-1:0] : '0;
            end
            dpt_pkg::ST_WALK:
            begin
                rd_en  = (eidx_reg != LAST_SLOT);
                alu_op = is_sweep ? dpt_pkg::OP_AGED : dpt_pkg::OP_MATCH;
                if (is_sweep)
                begin
                    wr.clr_used = rd_used && alu_hit;
                end
            end
            dpt_pkg::ST_APPLY:
            begin
                alu_op      = dpt_pkg::OP_NEWER;
                alu_ent     = rd_peer;
                alu_ent.seq = hit_seq_reg;
                if (!is_sweep)
                begin
                    if (req_reg.packet_kind == dpt_pkg::KIND_PRESENT)
                    begin
                        if (found_reg)
                        begin
                            wr_addr    = hit_reg;
                            wr.wr_time = 1'b1;
                            wr.wr_seq  = alu_hit;
                        end
                        else if (free_vld_reg)
                        begin
                            wr_addr     = free_reg;
                            wr.set_used = 1'b1;
                            wr.wr_ident = 1'b1;
                            wr.wr_seq   = 1'b1;
                            wr.wr_time  = 1'b1;
                        end
                    end
                    else if (found_reg)
                    begin
                        wr_addr     = hit_reg;
                        wr.clr_used = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        req_next       = req_reg;
        eidx_next      = eidx_reg;
        found_next     = found_reg;
        hit_next       = hit_reg;
        hit_seq_next   = hit_seq_reg;
        free_vld_next  = free_vld_reg;
        free_next      = free_reg;
        aged_next      = aged_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;

        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            dpt_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    req_next      = in_ch.item;
                    eidx_next     = '0;
                    found_next    = 1'b0;
                    free_vld_next = 1'b0;
                    aged_next     = '0;
                    res_next      = '0;
                end
            end
            dpt_pkg::ST_READ:
            begin
                res_next.action = dpt_pkg::ACT_READ;
                res_next.slot   = req_reg.read_slot;
                if (read_in_range && rd_used)
                begin
                    res_next.entry_valid     = 1'b1;
                    res_next.entry_address   = rd_peer.address;
                    res_next.entry_port      = rd_peer.port;
                    res_next.entry_seq       = rd_peer.seq;
                    res_next.entry_last_seen = rd_peer.last_seen;
                end
            end
            dpt_pkg::ST_WALK:
            begin
                eidx_next = eidx_reg + SLOT_W'(1);
                if (is_sweep)
                begin
                    if (rd_used && alu_hit)
                    begin
                        aged_next = aged_reg + CNT_W'(1);
                    end
                end
                else if (rd_used)
                begin
                    // lowest matching slot wins
                    if (!found_reg && alu_hit)
                    begin
                        found_next   = 1'b1;
                        hit_next     = eidx_reg;
                        hit_seq_next = rd_peer.seq;
                    end
                end
                else if (!free_vld_reg)
                begin
                    free_vld_next = 1'b1;
                    free_next     = eidx_reg;
                end
            end
            dpt_pkg::ST_APPLY:
            begin
                if (is_sweep)
                begin
                    res_next.action     = dpt_pkg::ACT_SWEPT;
                    res_next.aged_count = aged_wide[AG_W-1:0];
                end
                else if (req_reg.packet_kind == dpt_pkg::KIND_PRESENT)
                begin
                    if (found_reg)
                    begin
                        res_next.action = alu_hit ? dpt_pkg::ACT_REFRESHED_NEW :
                                                    dpt_pkg::ACT_REFRESHED;
                        res_next.slot   = hit_wide[RS_W-1:0];
                    end
                    else if (free_vld_reg)
                    begin
                        res_next.action = dpt_pkg::ACT_INSERTED;
                        res_next.slot   = free_wide[RS_W-1:0];
                    end
                    else
                    begin
                        res_next.action = dpt_pkg::ACT_DROPPED;
                    end
                end
                else if (found_reg)
                begin
                    res_next.action = dpt_pkg::ACT_REMOVED;
                    res_next.slot   = hit_wide[RS_W-1:0];
                end
            end
            dpt_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_item_next  = res_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dpt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg      <= req_next;
        eidx_reg     <= eidx_next;
        found_reg    <= found_next;
        hit_reg      <= hit_next;
        hit_seq_reg  <= hit_seq_next;
        free_vld_reg <= free_vld_next;
        free_reg     <= free_next;
        aged_reg     <= aged_next;
        res_reg      <= res_next;
        out_item_reg <= out_item_next;
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.item  = out_item_reg;
    assign req          = req_reg;

endmodule

// ===== hw/rtl/discovered_peer_table.sv =====
// Discovered peer table: top level with the register port.
//
// Requests enter on in_ch (valid/ready), one word per request: an announcement,
// an aging sweep or a slot read. Each request gives exactly one result word on
// out_ch. Registers (application id, match mode, time-to-live) sit on the APB
// port at byte addresses 0, 4 and 8; the user must write them only while the
// block idles, as the block itself does not enforce it. Announcements and
// sweeps walk the table through the peer memory one slot per cycle, since the
// memory has a single registered read port, and use one shared compare unit;
// the apply state then writes the update. Reads go through the read state;
// bad headers, foreign ids and unused request types go straight to the done
// state. in_ch.ready is high only between requests. A finished result sits in
// an output register, so the next request is accepted while out_ch stalls; a
// second result waits inside the block until the register frees up. Reset
// empties the table (slot flags clear at once, no clearing pass) and loads the
// register defaults; peer fields are written when a slot is filled.
`include "assert_macros.svh"

module discovered_peer_table #(
    parameter int TABLE_SLOTS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    dpt_in_if.sink                       in_ch,
    dpt_out_if.source                    out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dpt_pkg::PADDR_W-1:0]  paddr,
    input  logic [dpt_pkg::PDATA_W-1:0]  pwdata,
    output logic [dpt_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    localparam int SLOT_W = $clog2(TABLE_SLOTS);

    dpt_pkg::cfg_t       cfg_reg, cfg_next;
    logic                apb_wr;
    logic [1:0]          reg_idx;

    logic                rd_en;
    logic [SLOT_W-1:0]   rd_addr;
    dpt_pkg::peer_t      rd_peer;
    logic                rd_used;
    dpt_pkg::store_wr_t  st_wr;
    logic [SLOT_W-1:0]   wr_addr;
    dpt_pkg::peer_t      wr_peer;
    dpt_pkg::alu_op_t    alu_op;
    dpt_pkg::peer_t      alu_ent;
    logic                alu_hit;
    dpt_pkg::in_item_t   req;

    assign pready  = 1'b1;
    assign apb_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[dpt_pkg::PADDR_W-1:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (apb_wr)
        begin
            case (reg_idx)
                dpt_pkg::CFG_APP_ID:     cfg_next.app_id          = pwdata;
                dpt_pkg::CFG_MATCH_MODE: cfg_next.match_mode      = pwdata[0];
                dpt_pkg::CFG_TTL:        cfg_next.time_to_live_ms = pwdata;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            dpt_pkg::CFG_APP_ID:     prdata = cfg_reg.app_id;
            dpt_pkg::CFG_MATCH_MODE: prdata = {31'd0, cfg_reg.match_mode};
            dpt_pkg::CFG_TTL:        prdata = cfg_reg.time_to_live_ms;
            default:                 prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.app_id          <= '0;
            cfg_reg.match_mode      <= 1'b0;
            cfg_reg.time_to_live_ms <= dpt_pkg::TTL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    dpt_store #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_peer (rd_peer),
        .rd_used (rd_used),
        .wr      (st_wr),
        .wr_addr (wr_addr),
        .wr_peer (wr_peer)
    );

    dpt_alu u_alu (
        .op              (alu_op),
        .ent             (alu_ent),
        .match_mode      (cfg_reg.match_mode),
        .time_to_live_ms (cfg_reg.time_to_live_ms),
        .src_address     (req.src_address),
        .src_port        (req.src_port),
        .packet_seq      (req.packet_seq),
        .seq_restarted   (req.seq_restarted),
        .now_ms          (req.now_ms),
        .hit             (alu_hit)
    );

    dpt_ctrl #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_ch          (in_ch),
        .out_ch         (out_ch),
        .app_id         (cfg_reg.app_id),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .rd_peer        (rd_peer),
        .rd_used        (rd_used),
        .wr             (st_wr),
        .wr_addr        (wr_addr),
        .wr_peer        (wr_peer),
        .alu_op         (alu_op),
        .alu_ent        (alu_ent),
        .alu_hit        (alu_hit),
        .req            (req)
    );

    // one request in flight at a time
    `DPT_ASSERT_NEXT(a_one_in_flight, in_ch.valid && in_ch.ready, !in_ch.ready, "request accepted while busy")
    // a slot is never filled and freed in the same cycle
    `DPT_ASSERT_NOW(a_set_clr_excl, st_wr.set_used, !st_wr.clr_used, "slot set and cleared together")
    // table updates only happen while a request is being worked on
    `DPT_ASSERT_NOW(a_write_busy, st_wr.set_used || st_wr.clr_used || st_wr.wr_seq || st_wr.wr_time, !in_ch.ready, "table written while idle")

endmodule

// ===== tb/discovered_peer_table_test.sv =====
`timescale 1ns / 1ps
// Testbench of the discovered peer table: a directed table, then random phases, checked by a predictor.
module discovered_peer_table_test;
    import dpt_pkg::*;

    localparam int SLOTS        = 16;
    localparam int POOL         = 20;
    localparam int SHARED       = 6;
    localparam int PHASES       = 5;
    localparam int PHASE_WORDS  = 115;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        in_item_t  word;
        bit        typed;
        out_item_t result;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    dpt_in_if  req_ch ();
    dpt_out_if res_ch ();

    discovered_peer_table #(.TABLE_SLOTS(SLOTS)) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (req_ch),
        .out_ch  (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // predictor copy of the registers and the table
    logic [APPID_W-1:0] cfg_app_id = '0;
    logic               cfg_port_match = 1'b0;
    logic [TIME_W-1:0]  cfg_ttl = TTL_RESET;
    logic               peer_used [SLOTS];
    peer_t              peer_rec [SLOTS];

    out_item_t pending[$];
    int        errors = 0;
    bit        src_calm = 1'b0;
    bit        sink_calm = 1'b0;

    function automatic out_item_t table_update(in_item_t w);
        out_item_t r;
        int hit;
        int vacant;
        int aged;
        r = '0;
        hit = -1;
        vacant = -1;
        aged = 0;
        case (w.req_type)
            REQ_ANNOUNCE:
            begin
                if (w.header_valid && w.packet_app_id == cfg_app_id)
                begin
                    for (int s = 0; s < SLOTS; s++)
                    begin
                        if (peer_used[s])
                        begin
                            if (hit < 0 && peer_rec[s].address == w.src_address &&
                                (!cfg_port_match || peer_rec[s].port == w.src_port))
                                hit = s;
                        end
                        else if (vacant < 0)
                            vacant = s;
                    end
                    if (w.packet_kind == KIND_PRESENT)
                    begin
                        if (hit >= 0)
                        begin
                            r.action = ACT_REFRESHED;
                            if (w.seq_restarted || peer_rec[hit].seq < w.packet_seq)
                            begin
                                peer_rec[hit].seq = w.packet_seq;
                                r.action = ACT_REFRESHED_NEW;
                            end
                            peer_rec[hit].last_seen = w.now_ms;
                            r.slot = 4'(hit);
                        end
                        else if (vacant < 0)
                            r.action = ACT_DROPPED;
                        else
                        begin
                            peer_used[vacant] = 1'b1;
                            peer_rec[vacant] = '{w.src_address, w.src_port, w.packet_seq, w.now_ms};
                            r.action = ACT_INSERTED;
                            r.slot = 4'(vacant);
                        end
                    end
                    else if (hit >= 0)
                    begin
                        peer_used[hit] = 1'b0;
                        r.action = ACT_REMOVED;
                        r.slot = 4'(hit);
                    end
                end
            end
            REQ_SWEEP:
            begin
                for (int s = 0; s < SLOTS; s++)
                begin
                    // idle time wraps modulo 2^32
                    if (peer_used[s] && TIME_W'(w.now_ms - peer_rec[s].last_seen) > cfg_ttl)
                    begin
                        peer_used[s] = 1'b0;
                        aged++;
                    end
                end
                r.action = ACT_SWEPT;
                r.aged_count = 5'(aged);
            end
            REQ_READ:
            begin
                r.action = ACT_READ;
                r.slot = w.read_slot;
                if (peer_used[w.read_slot])
                begin
                    r.entry_valid = 1'b1;
                    r.entry_address = peer_rec[w.read_slot].address;
                    r.entry_port = peer_rec[w.read_slot].port;
                    r.entry_seq = peer_rec[w.read_slot].seq;
                    r.entry_last_seen = peer_rec[w.read_slot].last_seen;
                end
            end
            default:
                r = '0;
        endcase
        return r;
    endfunction

    function automatic in_item_t announce_word(logic [ADDR_W-1:0] addr, logic [PORT_W-1:0] port,
                                               logic hdr, logic [APPID_W-1:0] app, logic kind,
                                               logic [SEQ_W-1:0] seq, logic restarted,
                                               logic [TIME_W-1:0] now);
        in_item_t w;
        w = '0;
        w.req_type = REQ_ANNOUNCE;
        w.src_address = addr;
        w.src_port = port;
        w.header_valid = hdr;
        w.packet_app_id = app;
        w.packet_kind = kind;
        w.packet_seq = seq;
        w.seq_restarted = restarted;
        w.now_ms = now;
        return w;
    endfunction

    function automatic in_item_t plain_word(logic [REQ_W-1:0] req, logic [TIME_W-1:0] now,
                                            logic [RSLOT_W-1:0] rslot);
        in_item_t w;
        w = '0;
        w.req_type = req;
        w.now_ms = now;
        w.read_slot = rslot;
        return w;
    endfunction

    function automatic out_item_t outcome(logic [ACT_W-1:0] act, logic [RSLOT_W-1:0] slot,
                                          logic [AGED_W-1:0] aged);
        out_item_t r;
        r = '0;
        r.action = act;
        r.slot = slot;
        r.aged_count = aged;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    // a word is accepted at the edge where valid and ready are both high
    task automatic send_word(in_item_t w, bit typed, out_item_t typed_res);
        int gap;
        out_item_t predicted;
        gap = src_calm ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.item <= w;
        do
            @(posedge clk);
        while (!req_ch.ready);
        predicted = table_update(w);
        pending.insert(pending.size(), typed ? typed_res : predicted);
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        while (pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_config(logic [APPID_W-1:0] app, logic port_match,
                                logic [TIME_W-1:0] ttl);
        logic [1:0] reg_idx [3];
        logic [PDATA_W-1:0] value [3];
        reg_idx = '{CFG_APP_ID, CFG_MATCH_MODE, CFG_TTL};
        value = '{app, {31'd0, port_match}, ttl};
        for (int i = 0; i < 3; i++)
        begin
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= {reg_idx[i], 2'b00};
            pwdata <= value[i];
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        cfg_app_id = app;
        cfg_port_match = port_match;
        cfg_ttl = ttl;
    endtask

    initial
    begin : result_sink
        int stall;
        int taken;
        out_item_t want;
        stall = 0;
        taken = 0;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        res_ch.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (stall != 0)
            begin
                stall--;
                if (stall == 0)
                    res_ch.ready <= 1'b1;
            end
            else if (res_ch.valid && res_ch.ready)
            begin
                if (pending.size() == 0)
                begin
                    errors++;
                    $display("%0t: result word with nothing expected, action %0h slot %0h",
                             $time, res_ch.item.action, res_ch.item.slot);
                end
                else
                begin
                    want = pending.pop_front();
                    check_field("action", 32'(want.action), 32'(res_ch.item.action));
                    check_field("slot", 32'(want.slot), 32'(res_ch.item.slot));
                    check_field("aged_count", 32'(want.aged_count),
                                32'(res_ch.item.aged_count));
                    check_field("entry_valid", 32'(want.entry_valid),
                                32'(res_ch.item.entry_valid));
                    check_field("entry_address", want.entry_address,
                                res_ch.item.entry_address);
                    check_field("entry_port", 32'(want.entry_port),
                                32'(res_ch.item.entry_port));
                    check_field("entry_seq", 32'(want.entry_seq), 32'(res_ch.item.entry_seq));
                    check_field("entry_last_seen", want.entry_last_seen,
                                res_ch.item.entry_last_seen);
                end
                taken++;
                if (taken % 40 == 0)
                    sink_calm = ($urandom_range(0, 3) == 0);
                stall = sink_calm ? 0 : $urandom_range(0, 8);
                if (stall != 0)
                    res_ch.ready <= 1'b0;
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[discovered_peer_table] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        row_t plan[$];
        out_item_t r;
        in_item_t w;
        logic [ADDR_W-1:0] pool_addr [POOL];
        logic [PORT_W-1:0] pool_port [POOL];
        logic [SEQ_W-1:0]  pool_seq [POOL];
        logic [TIME_W-1:0] clock_ms;
        logic [APPID_W-1:0] app;
        logic port_match;
        logic [TIME_W-1:0] ttl;
        int pick;
        int k;

        req_ch.valid <= 1'b0;
        req_ch.item <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        for (int s = 0; s < SLOTS; s++)
            peer_used[s] = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, register defaults after reset
        plan.insert(plan.size(), '{plain_word(REQ_SWEEP, 32'd100, 4'd0), 1'b1,
                                   outcome(ACT_SWEPT, 4'd0, 5'd0)});
        plan.insert(plan.size(), '{plain_word(REQ_UNUSED, 32'hFFFF_FFFF, 4'hF), 1'b1,
                                   outcome(ACT_IGNORED, 4'd0, 5'd0)});
        plan.insert(plan.size(), '{announce_word(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'd0,
                                                 KIND_PRESENT, 30'h3FFF_FFFF, 1'b1,
                                                 32'hFFFF_FF00), 1'b1,
                                   outcome(ACT_INSERTED, 4'd0, 5'd0)});
        r = outcome(ACT_READ, 4'd0, 5'd0);
        r.entry_valid = 1'b1;
        r.entry_address = 32'hFFFF_FFFF;
        r.entry_port = 16'hFFFF;
        r.entry_seq = 30'h3FFF_FFFF;
        r.entry_last_seen = 32'hFFFF_FF00;
        plan.insert(plan.size(), '{plain_word(REQ_READ, 32'd0, 4'd0), 1'b1, r});
        // bad header, then a foreign application id
        plan.insert(plan.size(), '{announce_word(32'hFFFF_FFFF, 16'hFFFF, 1'b0, 32'd0,
                                                 KIND_PRESENT, 30'd0, 1'b0, 32'hFFFF_FF00),
                                   1'b1, outcome(ACT_IGNORED, 4'd0, 5'd0)});
        plan.insert(plan.size(), '{announce_word(32'hFFFF_FFFF, 16'hFFFF, 1'b1, 32'hFFFF_FFFF,
                                                 KIND_PRESENT, 30'd0, 1'b0, 32'hFFFF_FF00),
                                   1'b1, outcome(ACT_IGNORED, 4'd0, 5'd0)});
        // other port still matches on address alone; older index only refreshes time
        plan.insert(plan.size(), '{announce_word(32'hFFFF_FFFF, 16'h0000, 1'b1, 32'd0,
                                                 KIND_PRESENT, 30'd0, 1'b0, 32'hFFFF_FF00),
                                   1'b1, outcome(ACT_REFRESHED, 4'd0, 5'd0)});
        plan.insert(plan.size(), '{announce_word(32'hFFFF_FFFF, 16'h0000, 1'b1, 32'd0,
                                                 KIND_PRESENT, 30'd0, 1'b1, 32'hFFFF_FF00),
                                   1'b1, outcome(ACT_REFRESHED_NEW, 4'd0, 5'd0)});
        plan.insert(plan.size(), '{announce_word(32'd0, 16'd0, 1'b1, 32'd0, KIND_LEAVE, 30'd0,
                                                 1'b0, 32'hFFFF_FF00), 1'b1,
                                   outcome(ACT_IGNORED, 4'd0, 5'd0)});
        // idle exactly the ttl across the wrap, then one more ms
        plan.insert(plan.size(), '{plain_word(REQ_SWEEP, 32'h0000_1288, 4'd0), 1'b1,
                                   outcome(ACT_SWEPT, 4'd0, 5'd0)});
        plan.insert(plan.size(), '{plain_word(REQ_SWEEP, 32'h0000_1289, 4'd0), 1'b1,
                                   outcome(ACT_SWEPT, 4'd0, 5'd1)});
        plan.insert(plan.size(), '{plain_word(REQ_READ, 32'd0, 4'd0), 1'b1,
                                   outcome(ACT_READ, 4'd0, 5'd0)});
        for (int i = 0; i < SLOTS; i++)
            plan.insert(plan.size(), '{announce_word(i * 32'h0101_0101, 16'(i), 1'b1, 32'd0,
                                                     KIND_PRESENT, 30'(i), 1'b0,
                                                     32'h0000_2000), 1'b1,
                                       outcome(ACT_INSERTED, 4'(i), 5'd0)});
        plan.insert(plan.size(), '{announce_word(32'h1234_5678, 16'h4321, 1'b1, 32'd0,
                                                 KIND_PRESENT, 30'd9, 1'b0, 32'h0000_2001),
                                   1'b1, outcome(ACT_DROPPED, 4'd0, 5'd0)});
        foreach (plan[i])
            send_word(plan[i].word, plan[i].typed, plan[i].result);

        // random phases, each with its own register setting
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: begin app = $urandom(); port_match = 1'b1; ttl = 32'd2000; end
                1: begin app = 32'hFFFF_FFFF; port_match = 1'b0; ttl = 32'd0; end
                2: begin app = 32'd0; port_match = 1'b1; ttl = 32'hFFFF_FFFF; end
                3: begin app = $urandom(); port_match = 1'b0; ttl = $urandom_range(500, 20000); end
                default: begin app = $urandom(); port_match = 1'b1; ttl = 32'd3000; end
            endcase
            drain();
            write_config(app, port_match, ttl);
            for (int p = 0; p < POOL; p++)
            begin
                // the last few share an address with an earlier peer, on another port
                pool_addr[p] = (p >= POOL - SHARED) ? pool_addr[p - (POOL - SHARED)] : $urandom();
                pool_port[p] = 16'($urandom());
                pool_seq[p] = 30'($urandom());
            end
            clock_ms = $urandom();
            src_calm = ($urandom_range(0, 3) == 0);

            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (ph == 2 && n == PHASE_WORDS / 2)
                    drain();
                w.src_address = $urandom();
                w.src_port = 16'($urandom());
                w.header_valid = 1'($urandom());
                w.packet_app_id = $urandom();
                w.packet_kind = 1'($urandom());
                w.packet_seq = 30'($urandom());
                w.seq_restarted = 1'($urandom());
                w.read_slot = 4'($urandom());
                if ($urandom_range(0, 49) == 0)
                    clock_ms = clock_ms + $urandom();
                else
                    clock_ms = clock_ms + $urandom_range(0, 300);
                w.now_ms = clock_ms;
                pick = $urandom_range(0, 99);
                if (pick < 65)
                begin
                    w.req_type = REQ_ANNOUNCE;
                    k = $urandom_range(0, POOL - 1);
                    if ($urandom_range(0, 9) != 0)
                    begin
                        w.header_valid = 1'b1;
                        w.packet_app_id = cfg_app_id;
                        if ($urandom_range(0, 9) != 0)
                        begin
                            w.src_address = pool_addr[k];
                            w.src_port = pool_port[k];
                            case ($urandom_range(0, 9))
                                0:
                                begin
                                    pool_seq[k] = SEQ_W'($urandom_range(0, 3));
                                    w.seq_restarted = 1'b1;
                                end
                                1: pool_seq[k] = w.packet_seq;
                                default:
                                begin
                                    pool_seq[k] = pool_seq[k] + SEQ_W'($urandom_range(0, 3))
                                                  - SEQ_W'(1);
                                    w.seq_restarted = 1'b0;
                                end
                            endcase
                            w.packet_seq = pool_seq[k];
                            w.packet_kind = ($urandom_range(0, 6) == 0) ? KIND_LEAVE : KIND_PRESENT;
                        end
                    end
                    else if (w.header_valid)
                    begin
                        // well-known sender with an id one bit off
                        w.src_address = pool_addr[k];
                        w.packet_app_id = cfg_app_id ^ (32'd1 << $urandom_range(0, 31));
                    end
                end
                else if (pick < 77)
                begin
                    w.req_type = REQ_SWEEP;
                    k = $urandom_range(0, SLOTS - 1);
                    if ($urandom_range(0, 3) == 0 && peer_used[k])
                    begin
                        // land right on the ttl boundary of one peer
                        clock_ms = peer_rec[k].last_seen + cfg_ttl + $urandom_range(0, 1);
                        w.now_ms = clock_ms;
                    end
                end
                else if (pick < 95)
                    w.req_type = REQ_READ;
                else
                    w.req_type = REQ_UNUSED;
                send_word(w, 1'b0, '0);
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && pending.size() == 0)
            $display("[discovered_peer_table] OK");
        else
            $display("[discovered_peer_table] ERROR");
        $finish;
    end

endmodule
